### hw/rtl/bhq_pkg.sv
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared types and codes of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bhq_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_W        = 32;
  localparam int ID_W         = 16;

  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_CHANGE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  localparam int ENTRY_W = KEY_W + ID_W;

  // finished transaction handed to the output register
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } result_t;

endpackage

### hw/rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue of (key, id) entries with push, pop and change.
// ----------------------------------------------------------------------------
// Input channel in_*: kind (0 push, 1 pop, 2 change priority), key, item_id.
// Output channel out_*: one result per transaction with the root entry
// (zero when empty), entry count, empty flag and status.
// Transactions complete at a rising edge with valid high and stall low.
// One transaction at a time; in_stall stays high until its result is
// loaded into the output register.
// Work is paced by the single read port of the entry memory. Refused and
// unused kinds go straight to the result; push climbs one level per compare
// and writes the root last when it reaches it (directly on an empty heap);
// pop moves the last entry to the root and sifts it down (no sift when at
// most one entry remains). Change scans entries in order up to the match,
// then rebuilds from count/2 down to 0 by sifting each node down.
// A stalled result stays in the output register; the next transaction may
// be accepted and worked on, but its result waits until the slot frees.
// Reset clears the count and control state; the memory is not cleared.
// ----------------------------------------------------------------------------
module binary_min_heap_queue
  import bhq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_kind,
  input  logic [KEY_W-1:0] in_key,
  input  logic [ID_W-1:0]  in_item_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] out_head_key,
  output logic [ID_W-1:0]  out_head_id,
  output logic [CW-1:0]    out_entry_count,
  output logic             out_is_empty,
  output logic [1:0]       out_status
);

  localparam int AW = $clog2(CAPACITY);

  logic          busy, take;
  result_t       res;
  entry_t        head;
  logic [CW-1:0] count;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic          out_valid_r;

  assign in_stall = busy;
  assign take     = res.valid && (!out_valid_r || !out_stall);

  bhq_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
    .clk, .rst_n,
    .start(in_valid && !busy), .kind(in_kind), .key(in_key),
    .item_id(in_item_id), .busy, .res, .res_take(take), .head, .count,
    .mem_we(we), .mem_waddr(waddr), .mem_wdata(wdata),
    .mem_re(re), .mem_raddr(raddr), .mem_rdata(rdata)
  );

  bhq_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_head_key    <= (count == '0) ? '0 : head.key;
      out_head_id     <= (count == '0) ? '0 : head.id;
      out_entry_count <= count;
      out_is_empty    <= count == '0;
      out_status      <= res.status;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/bhq_mem.sv
// ----------------------------------------------------------------------------
// bhq_mem
// Heap entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bhq_mem
  import bhq_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/bhq_ctrl.sv
// ----------------------------------------------------------------------------
// bhq_ctrl
// Heap sequencer: sift-up for push, sift-down for pop, id scan and
// bottom-up rebuild for change priority. Tracks count and the root entry.
// ----------------------------------------------------------------------------
module bhq_ctrl
  import bhq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       kind,
  input  logic [KEY_W-1:0] key,
  input  logic [ID_W-1:0]  item_id,
  output logic             busy,
  output result_t          res,
  input  logic             res_take,
  output entry_t           head,
  output logic [CW-1:0]    count,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output entry_t           mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  entry_t           mem_rdata
);

  localparam int IW = CW + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_PU_CMP, S_PU_FIN, S_PO_WR, S_CH_CHK,
    S_SD_P, S_SD_L, S_SD_R, S_SD_C, S_SD_W, S_DONE
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] idx_r, pos_r, outer_r, best_r;
  entry_t        nk_r, cur_r, lft_r, head_r;
  logic [1:0]    st_r;

  logic [AW-1:0] par_idx, par_par;
  logic [IW-1:0] l_w, r_w, lb_w;
  logic          l_ok, r_ok, lb_ok;
  logic          pick_l, pick_r;
  logic [AW-1:0] best_c;
  entry_t        best_e;

  assign par_idx = AW'((idx_r - AW'(1)) >> 1);
  assign par_par = AW'((par_idx - AW'(1)) >> 1);

  assign l_w   = IW'({pos_r, 1'b0}) + IW'(1);
  assign r_w   = IW'({pos_r, 1'b0}) + IW'(2);
  assign l_ok  = l_w < IW'(cnt_r);
  assign r_ok  = r_w < IW'(cnt_r);
  assign lb_w  = IW'({best_r, 1'b0}) + IW'(1);
  assign lb_ok = lb_w < IW'(cnt_r);

  // smallest of node, left, right; left wins a tie against right
  always_comb begin
    pick_l = l_ok && (lft_r.key < cur_r.key);
    pick_r = r_ok && (mem_rdata.key < (pick_l ? lft_r.key : cur_r.key));
    if (pick_r) begin
      best_c = AW'(r_w);
      best_e = mem_rdata;
    end else if (pick_l) begin
      best_c = AW'(l_w);
      best_e = lft_r;
    end else begin
      best_c = pos_r;
      best_e = cur_r;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = nk_r;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mem_re = 1'b1;
          unique case (kind)
            KIND_PUSH:   mem_raddr = AW'((cnt_r - CW'(1)) >> 1);
            KIND_POP:    mem_raddr = AW'(cnt_r - CW'(1));
            default:     mem_raddr = '0;
          endcase
          if (kind == KIND_PUSH && cnt_r == '0) begin
            mem_we    = 1'b1;
            mem_wdata = '{key: key, id: item_id};
          end
        end
      end
      S_PU_CMP: begin
        mem_we = 1'b1;
        mem_waddr = idx_r;
        if (mem_rdata.key > nk_r.key) begin
          mem_wdata = mem_rdata;
          mem_re    = par_idx != '0;
          mem_raddr = par_par;
        end
      end
      S_PU_FIN: begin
        mem_we = 1'b1;
        mem_waddr = idx_r;
      end
      S_PO_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
      end
      S_CH_CHK: begin
        if (mem_rdata.id == nk_r.id) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          mem_wdata = '{key: nk_r.key, id: mem_rdata.id};
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + AW'(1);
        end
      end
      S_SD_P: begin
        mem_re    = 1'b1;
        mem_raddr = pos_r;
      end
      S_SD_L: begin
        mem_re    = l_ok;
        mem_raddr = AW'(l_w);
      end
      S_SD_R: begin
        mem_re    = r_ok;
        mem_raddr = AW'(r_w);
      end
      S_SD_C: begin
        mem_we    = best_c != pos_r;
        mem_waddr = pos_r;
        mem_wdata = best_e;
      end
      S_SD_W: begin
        mem_we    = 1'b1;
        mem_waddr = best_r;
        mem_wdata = cur_r;
        mem_re    = lb_ok;
        mem_raddr = AW'(lb_w);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      st_r    <= ST_OK;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            nk_r <= '{key: key, id: item_id};
            st_r <= ST_OK;
            unique case (kind)
              KIND_PUSH: begin
                if (cnt_r == CAP_C) begin
                  st_r    <= ST_FULL;
                  state_r <= S_DONE;
                end else begin
                  cnt_r   <= cnt_r + CW'(1);
                  idx_r   <= AW'(cnt_r);
                  state_r <= (cnt_r == '0) ? S_DONE : S_PU_CMP;
                end
              end
              KIND_POP: begin
                if (cnt_r == '0) begin
                  st_r    <= ST_EMPTY;
                  state_r <= S_DONE;
                end else begin
                  cnt_r   <= cnt_r - CW'(1);
                  state_r <= (cnt_r == CW'(1)) ? S_DONE : S_PO_WR;
                end
              end
              KIND_CHANGE: begin
                idx_r <= '0;
                if (cnt_r == '0) begin
                  st_r    <= ST_NOTFOUND;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_CH_CHK;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_PU_CMP: begin
          if (mem_rdata.key > nk_r.key) begin
            idx_r   <= par_idx;
            state_r <= (par_idx == '0) ? S_PU_FIN : S_PU_CMP;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_PU_FIN: state_r <= S_DONE;
        S_PO_WR: begin
          cur_r   <= mem_rdata;
          pos_r   <= '0;
          outer_r <= '0;
          state_r <= (cnt_r == CW'(1)) ? S_DONE : S_SD_R;
        end
        S_CH_CHK: begin
          if (mem_rdata.id == nk_r.id) begin
            outer_r <= AW'(cnt_r >> 1);
            pos_r   <= AW'(cnt_r >> 1);
            state_r <= S_SD_P;
          end else if (CW'(idx_r) + CW'(1) < cnt_r) begin
            idx_r <= idx_r + AW'(1);
          end else begin
            st_r    <= ST_NOTFOUND;
            state_r <= S_DONE;
          end
        end
        S_SD_P: state_r <= S_SD_L;
        S_SD_L: begin
          cur_r   <= mem_rdata;
          state_r <= S_SD_R;
        end
        S_SD_R: begin
          if (l_ok) begin
            lft_r <= mem_rdata;
          end
          state_r <= S_SD_C;
        end
        S_SD_C: begin
          if (best_c != pos_r) begin
            best_r  <= best_c;
            state_r <= S_SD_W;
          end else if (outer_r == '0) begin
            state_r <= S_DONE;
          end else begin
            outer_r <= outer_r - AW'(1);
            pos_r   <= outer_r - AW'(1);
            state_r <= S_SD_P;
          end
        end
        S_SD_W: begin
          pos_r   <= best_r;
          state_r <= S_SD_R;
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // root entry mirror
  always_ff @(posedge clk) begin
    if (mem_we && mem_waddr == '0) begin
      head_r <= mem_wdata;
    end
  end

  assign busy       = state_r != S_IDLE;
  assign res.valid  = state_r == S_DONE;
  assign res.status = st_r;
  assign head       = head_r;
  assign count      = cnt_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C) else $error("count above capacity");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> mem_waddr != mem_raddr)
    else $error("read and write of one entry in one cycle");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && $past(state_r) != S_IDLE) |-> $stable(cnt_r))
    else $error("count changed mid transaction");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE) else $error("start while busy");
`endif

endmodule
